### rtl/core/gcnl_pkg.sv
// Shared types, constants and helpers for the grid cell neighbor list block.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package gcnl_pkg;

    // Largest usable grid dimension along any axis
    localparam int DIM_MAX     = 1024;
    localparam int CFG_W       = 11;
    localparam int IDX_W       = 30;
    localparam int NBR_W       = 32;
    localparam int SLOT_W      = 5;
    localparam int NEIGH_COUNT = 27;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam int DIM_W       = $clog2(DIM_MAX + 1);
    localparam int CRD_W       = $clog2(DIM_MAX);
    localparam int PLN_W       = 2 * DIM_W;

    // Iterative divider: DIG_W quotient bits per cycle
    localparam int DIG_W       = 4;
    localparam int DVD_W       = ((IDX_W + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int DIV_STEPS   = DVD_W / DIG_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

    localparam logic [SLOT_W-1:0] LAST_SLOT    = SLOT_W'(NEIGH_COUNT - 1);
    localparam logic [NBR_W-1:0]  OUTSIDE_MARK = '1;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DIM_X = 2'd0;
    localparam logic [1:0] REG_DIM_Y = 2'd1;
    localparam logic [1:0] REG_DIM_Z = 2'd2;

    // Offset codes along one axis
    localparam logic [1:0] OFS_LO  = 2'd0;
    localparam logic [1:0] OFS_MID = 2'd1;
    localparam logic [1:0] OFS_HI  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] ex;
        logic [DIM_W-1:0] ey;
        logic [DIM_W-1:0] ez;
        logic [PLN_W-1:0] plane;
        logic [NBR_W-1:0] step_y;   // from x=+1 back to x=-1 on the next row
        logic [NBR_W-1:0] step_z;   // from (+1,+1) back to (-1,-1) on the next plane
    } gcnl_geom_t;

    // One classified request waiting for the back end
    typedef struct packed {
        logic [NBR_W-1:0] base;     // index of the (-1,-1,-1) neighbor, mod 2^32
        logic             x_lo;
        logic             x_hi;
        logic             y_lo;
        logic             y_hi;
        logic             z_lo;
        logic             z_mid;
        logic             z_hi;
    } gcnl_item_t;

    // Zero acts as one, anything above DIM_MAX acts as DIM_MAX
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > 32'(DIM_MAX))
            r = DIM_W'(DIM_MAX);
        else
            r = DIM_W'(v);
        return r;
    endfunction

endpackage

### rtl/core/grid_cell_neighbor_list.sv
// Top level of the 27-cell neighbor list generator: config registers,
// grid geometry, front end, request queue and back end.
// Depends on gcnl_pkg and all gcnl_* modules.
`timescale 1ns / 1ps

// Usage
//   Config: APB-style port, dim_x/dim_y/dim_z at byte addresses 0, 4, 8
//   (11 bits each, reset 1). Write them only while the block is idle.
//   Request: drive cell_index with start high; it is taken on an edge where
//   busy is low. busy then stays high while the shared
//   divider splits the index into x, y, z (two divisions of 8 steps, each
//   ending in a done strobe, then the push), and longer if the two-entry
//   queue to the back end is full.
//   Results: 27 per request on consecutive cycles, each marked by valid for
//   one cycle, slots 0..26 in z, y, x order, is_last on slot 26. Results of
//   successive requests follow with no gap when the next one is already queued.
//   First result: with the back end idle, valid rises once the request has
//   passed the front end, the queue, the back end and its output registers.
//   The sustained request rate is set by the back end, which emits one result
//   per cycle, 27 per request.
//   The receiver cannot stall; results are never held.
//   Reset: queue empty, no results pending, dimensions back to 1.

module grid_cell_neighbor_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gcnl_pkg::ADDR_W-1:0]   paddr,
    input  logic [gcnl_pkg::DATA_W-1:0]   pwdata,
    output logic [gcnl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    input  logic [gcnl_pkg::IDX_W-1:0]    cell_index,
    output logic                          busy,
    output logic                          valid,
    output logic [gcnl_pkg::NBR_W-1:0]    neighbor_index,
    output logic [gcnl_pkg::SLOT_W-1:0]   slot,
    output logic                          is_last
);
    import gcnl_pkg::*;

    logic [CFG_W-1:0]   dim_x_reg;
    logic [CFG_W-1:0]   dim_y_reg;
    logic [CFG_W-1:0]   dim_z_reg;
    logic [PLN_W-1:0]   plane_reg;
    logic [NBR_W-1:0]   step_y_reg;
    logic [NBR_W-1:0]   step_z_reg;

    logic [DIM_W-1:0]   eff_x;
    logic [DIM_W-1:0]   eff_y;
    logic [DIM_W-1:0]   eff_z;
    logic [1:0]         reg_sel;
    logic               cfg_wr;

    gcnl_geom_t         geom;
    gcnl_item_t         push_item;
    gcnl_item_t         pop_item;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg <= CFG_W'(1);
            dim_y_reg <= CFG_W'(1);
            dim_z_reg <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_DIM_X: dim_x_reg <= pwdata[CFG_W-1:0];
                REG_DIM_Y: dim_y_reg <= pwdata[CFG_W-1:0];
                REG_DIM_Z: dim_z_reg <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DIM_X: prdata = DATA_W'(dim_x_reg);
            REG_DIM_Y: prdata = DATA_W'(dim_y_reg);
            REG_DIM_Z: prdata = DATA_W'(dim_z_reg);
            default:   prdata = '0;
        endcase
    end

    assign eff_x = eff_dim(dim_x_reg);
    assign eff_y = eff_dim(dim_y_reg);
    assign eff_z = eff_dim(dim_z_reg);

    // plane and row steps are needed only at the end of the divisions
    always_ff @(posedge clk)
    begin
        plane_reg  <= PLN_W'(eff_x) * PLN_W'(eff_y);
        step_y_reg <= NBR_W'(eff_x) - NBR_W'(2);
        step_z_reg <= NBR_W'(plane_reg) - (NBR_W'(eff_x) << 1) - NBR_W'(2);
    end

    always_comb
    begin
        geom.ex     = eff_x;
        geom.ey     = eff_y;
        geom.ez     = eff_z;
        geom.plane  = plane_reg;
        geom.step_y = step_y_reg;
        geom.step_z = step_z_reg;
    end

    gcnl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cell_index (cell_index),
        .busy       (busy),
        .geom       (geom),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    gcnl_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (push_item),
        .pop     (q_pop),
        .rd_item (pop_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    gcnl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .geom           (geom),
        .q_item         (pop_item),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .valid          (valid),
        .neighbor_index (neighbor_index),
        .slot           (slot),
        .is_last        (is_last)
    );

endmodule

### rtl/core/gcnl_div.sv
// Iterative unsigned divider, DIG_W quotient bits per cycle over DIV_STEPS steps.
// Depends on gcnl_pkg.
`timescale 1ns / 1ps

module gcnl_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [gcnl_pkg::DVD_W-1:0]   dividend,
    input  logic [gcnl_pkg::DIM_W-1:0]   divisor,
    output logic                         done,
    output logic [gcnl_pkg::DVD_W-1:0]   quotient,
    output logic [gcnl_pkg::DIM_W-1:0]   remainder
);
    import gcnl_pkg::*;

    logic                run_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [DIM_W-1:0]    rem_reg;
    logic [DIM_W-1:0]    dsr_reg;

    logic [DIM_W-1:0]    rem_next;
    logic [DIG_W-1:0]    qdig;
    logic                last_step;

    // Restoring steps; remainder stays below the divisor so DIM_W-1 bits carry it
    always_comb
    begin
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] t;
        r    = rem_reg;
        qdig = '0;
        for (int i = 0; i < DIG_W; i++)
        begin
            t = {r[DIM_W-2:0], dvd_reg[DVD_W-1-i]};
            if (t >= dsr_reg)
            begin
                r              = t - dsr_reg;
                qdig[DIG_W-1-i] = 1'b1;
            end
            else
            begin
                r = t;
            end
        end
        rem_next = r;
    end

    assign last_step = (cnt_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (run_reg)
            begin
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (last_step)
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-DIG_W-1:0], qdig};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### rtl/core/gcnl_front.sv
// Front end: accepts a cell index, splits it into coordinates with the shared
// divider and pushes a classified request into the queue. Depends on gcnl_pkg, gcnl_div.
`timescale 1ns / 1ps

module gcnl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gcnl_pkg::IDX_W-1:0]    cell_index,
    output logic                          busy,
    input  gcnl_pkg::gcnl_geom_t          geom,
    input  logic                          q_full,
    output logic                          q_push,
    output gcnl_pkg::gcnl_item_t          q_item
);
    import gcnl_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIVX = 4'b0010,
        F_DIVY = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t        state_reg;
    front_state_t        state_next;
    logic [IDX_W-1:0]    cell_reg;
    logic [CRD_W-1:0]    cx_reg;
    logic [CRD_W-1:0]    cy_reg;
    logic [IDX_W-1:0]    cz_reg;

    logic                div_load;
    logic [DVD_W-1:0]    div_dividend;
    logic [DIM_W-1:0]    div_divisor;
    logic                div_done;
    logic [DVD_W-1:0]    div_quo;
    logic [DIM_W-1:0]    div_rem;

    gcnl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (div_load),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next   = state_reg;
        div_load     = 1'b0;
        div_dividend = DVD_W'(cell_index);
        div_divisor  = geom.ex;
        q_push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    div_load   = 1'b1;
                    state_next = F_DIVX;
                end
            end
            F_DIVX:
            begin
                // x = c mod ex, then divide the quotient by ey
                div_dividend = div_quo;
                div_divisor  = geom.ey;
                if (div_done)
                begin
                    div_load   = 1'b1;
                    state_next = F_DIVY;
                end
            end
            F_DIVY:
            begin
                if (div_done)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && start)
            cell_reg <= cell_index;
        if (state_reg == F_DIVX && div_done)
            cx_reg <= div_rem[CRD_W-1:0];
        if (state_reg == F_DIVY && div_done)
        begin
            cy_reg <= div_rem[CRD_W-1:0];
            cz_reg <= div_quo[IDX_W-1:0];
        end
    end

    // cz may exceed the grid when the index is past the last cell
    always_comb
    begin
        q_item.base  = NBR_W'(cell_reg) - NBR_W'(geom.plane) - NBR_W'(geom.ex)
                       - NBR_W'(1);
        q_item.x_lo  = (cx_reg != '0);
        q_item.x_hi  = ((DIM_W'(cx_reg) + DIM_W'(1)) < geom.ex);
        q_item.y_lo  = (cy_reg != '0);
        q_item.y_hi  = ((DIM_W'(cy_reg) + DIM_W'(1)) < geom.ey);
        q_item.z_lo  = (cz_reg != '0) && (cz_reg <= IDX_W'(geom.ez));
        q_item.z_mid = (cz_reg < IDX_W'(geom.ez));
        q_item.z_hi  = (((IDX_W + 1)'(cz_reg) + (IDX_W + 1)'(1)) < (IDX_W + 1)'(geom.ez));
    end

    assign busy = (state_reg != F_IDLE);

endmodule

### rtl/core/gcnl_fifo.sv
// Short request queue between front end and back end.
// Depends on gcnl_pkg.
`timescale 1ns / 1ps

module gcnl_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  gcnl_pkg::gcnl_item_t  wr_item,
    input  logic                  pop,
    output gcnl_pkg::gcnl_item_t  rd_item,
    output logic                  full,
    output logic                  empty
);
    import gcnl_pkg::*;

    gcnl_item_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;

    assign full    = (count_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (FIFO_PTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (FIFO_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

### rtl/core/gcnl_back.sv
// Back end: walks the 27 offsets of one request, one result per cycle,
// stepping the neighbor index by adds. Depends on gcnl_pkg.
`timescale 1ns / 1ps

module gcnl_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gcnl_pkg::gcnl_geom_t          geom,
    input  gcnl_pkg::gcnl_item_t          q_item,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          valid,
    output logic [gcnl_pkg::NBR_W-1:0]    neighbor_index,
    output logic [gcnl_pkg::SLOT_W-1:0]   slot,
    output logic                          is_last
);
    import gcnl_pkg::*;

    logic                active_reg;
    logic [1:0]          xs_reg;
    logic [1:0]          ys_reg;
    logic [1:0]          zs_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [NBR_W-1:0]    idx_reg;
    gcnl_item_t          cur_reg;

    logic                valid_reg;
    logic [NBR_W-1:0]    nbr_out_reg;
    logic [SLOT_W-1:0]   slot_out_reg;
    logic                last_out_reg;

    logic                at_last;
    logic                in_grid;
    logic [NBR_W-1:0]    idx_next;

    function automatic logic axis_ok(input logic [1:0] code, input logic lo,
                                     input logic mid, input logic hi);
        logic r;
        case (code)
            OFS_LO:  r = lo;
            OFS_MID: r = mid;
            OFS_HI:  r = hi;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    assign at_last = (slot_reg == LAST_SLOT);
    assign q_pop   = !q_empty && (!active_reg || at_last);
    assign in_grid = axis_ok(xs_reg, cur_reg.x_lo, 1'b1, cur_reg.x_hi)
                  && axis_ok(ys_reg, cur_reg.y_lo, 1'b1, cur_reg.y_hi)
                  && axis_ok(zs_reg, cur_reg.z_lo, cur_reg.z_mid, cur_reg.z_hi);

    always_comb
    begin
        if (xs_reg != OFS_HI)
            idx_next = idx_reg + NBR_W'(1);
        else if (ys_reg != OFS_HI)
            idx_next = idx_reg + geom.step_y;
        else
            idx_next = idx_reg + geom.step_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            slot_reg   <= '0;
            xs_reg     <= OFS_LO;
            ys_reg     <= OFS_LO;
            zs_reg     <= OFS_LO;
        end
        else
        begin
            valid_reg <= active_reg;
            if (q_pop)
            begin
                active_reg <= 1'b1;
                slot_reg   <= '0;
                xs_reg     <= OFS_LO;
                ys_reg     <= OFS_LO;
                zs_reg     <= OFS_LO;
            end
            else if (active_reg)
            begin
                if (at_last)
                    active_reg <= 1'b0;
                slot_reg <= slot_reg + SLOT_W'(1);
                if (xs_reg != OFS_HI)
                begin
                    xs_reg <= xs_reg + 2'd1;
                end
                else if (ys_reg != OFS_HI)
                begin
                    xs_reg <= OFS_LO;
                    ys_reg <= ys_reg + 2'd1;
                end
                else
                begin
                    xs_reg <= OFS_LO;
                    ys_reg <= OFS_LO;
                    zs_reg <= zs_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
            idx_reg <= q_item.base;
        end
        else if (active_reg)
        begin
            idx_reg <= idx_next;
        end
        nbr_out_reg  <= in_grid ? idx_reg : OUTSIDE_MARK;
        slot_out_reg <= slot_reg;
        last_out_reg <= at_last;
    end

    assign valid          = valid_reg;
    assign neighbor_index = nbr_out_reg;
    assign slot           = slot_out_reg;
    assign is_last        = last_out_reg;

endmodule
